### src/pf_dec_pkg.sv
// Shared types and constants for the Playfair key-square decryptor.
// Holds the command codes and the input and result word formats.
// No dependencies.
`default_nettype none

package pf_dec_pkg;

    localparam int GRID_SIDE   = 5;
    localparam int CELL_COUNT  = GRID_SIDE * GRID_SIDE;
    localparam int ALPHA_COUNT = 26;
    localparam int LETTER_W    = 5;
    localparam int POS_W       = $clog2(CELL_COUNT);
    localparam int ROW_W       = $clog2(GRID_SIDE);

    localparam logic [LETTER_W-1:0] CODE_A = LETTER_W'(0);
    localparam logic [LETTER_W-1:0] CODE_I = LETTER_W'(8);
    localparam logic [LETTER_W-1:0] CODE_J = LETTER_W'(9);
    localparam logic [LETTER_W-1:0] CODE_Z = LETTER_W'(25);

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_KEY     = 2'd1,
        CMD_FINISH  = 2'd2,
        CMD_DECRYPT = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                cmd;
        logic [LETTER_W-1:0] letter_a;
        logic [LETTER_W-1:0] letter_b;
    } t_in_word;

    typedef struct packed {
        logic [LETTER_W-1:0] plain_a;
        logic [LETTER_W-1:0] plain_b;
        logic                square_ready;
    } t_out_word;

endpackage

`default_nettype wire

### src/playfair_decrypt.sv
// Playfair 5x5 key-square builder and letter-pair decryptor, top level.
// Depends on pf_dec_pkg for the word formats, command codes and constants.
`default_nettype none

// Usage overview. Each input word carries a command. Clear empties the square.
// A key letter (J is taken as I) is appended if it is not yet in the square.
// Finish walks the alphabet A to Z, one letter per cycle, appending every
// unused letter except J, so it keeps the input stalled until the walk has
// reached Z. A decrypt word produces exactly one result word; the other
// commands produce none. On a finished square a decrypt keeps the input
// stalled while it steps through ST_LOOKUP, ST_CELL and ST_EMIT: the position
// memory is read at the accepting edge, the cell memory in ST_LOOKUP, ST_CELL
// is a spare step, and the result register is loaded in ST_EMIT. Both memories
// have two registered read ports and one write port. A new input word is
// accepted on the cycle after the previous one finished, even while a result
// still waits in the output register; a decrypt only stalls at its last step
// if that register is still occupied. A decrypt issued before the square was
// finished skips the memory reads, stalls the input only in ST_EMIT and returns
// zero letters with square_ready low. Cipher letters above Z are taken as Z,
// and J is taken as I.
module playfair_decrypt (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire pf_dec_pkg::t_in_word i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output pf_dec_pkg::t_out_word o_out_word
);

    localparam int LW = pf_dec_pkg::LETTER_W;
    localparam int PW = pf_dec_pkg::POS_W;
    localparam int RW = pf_dec_pkg::ROW_W;
    localparam int NC = pf_dec_pkg::CELL_COUNT;
    localparam int NA = pf_dec_pkg::ALPHA_COUNT;
    localparam int SIDE = pf_dec_pkg::GRID_SIDE;
    localparam logic [RW-1:0] LAST_IDX = RW'(SIDE - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FILL   = 5'b00010,
        ST_LOOKUP = 5'b00100,
        ST_CELL   = 5'b01000,
        ST_EMIT   = 5'b10000
    } t_state;

    // J folds to I; in the cipher path anything above Z saturates first.
    function automatic logic [LW-1:0] fold_key(input logic [LW-1:0] code);
        fold_key = (code == pf_dec_pkg::CODE_J) ? pf_dec_pkg::CODE_I : code;
    endfunction

    function automatic logic [LW-1:0] fold_cipher(input logic [LW-1:0] code);
        logic [LW-1:0] sat;
        sat = (code > pf_dec_pkg::CODE_Z) ? pf_dec_pkg::CODE_Z : code;
        fold_cipher = fold_key(sat);
    endfunction

    // Row of a cell index below 25: multiply by 13 and drop six bits.
    function automatic logic [RW-1:0] pos_row(input logic [PW-1:0] pos);
        logic [PW+4-1:0] prod;
        prod = (PW+4)'(pos) * (PW+4)'(13);
        pos_row = RW'(prod >> 6);
    endfunction

    function automatic logic [RW-1:0] pos_col(input logic [PW-1:0] pos);
        logic [PW-1:0] base;
        base = PW'(pos_row(pos)) * PW'(SIDE);
        pos_col = RW'(pos - base);
    endfunction

    function automatic logic [PW-1:0] cell_index(input logic [RW-1:0] row,
                                                 input logic [RW-1:0] col);
        cell_index = PW'(row) * PW'(SIDE) + PW'(col);
    endfunction

    function automatic logic [RW-1:0] step_back(input logic [RW-1:0] idx);
        step_back = (idx == '0) ? LAST_IDX : idx - RW'(1);
    endfunction

    // Control state.
    t_state           r_state, n_state;
    logic [NA-1:0]    r_used, n_used;
    logic [PW-1:0]    r_fill, n_fill;
    logic             r_ready, n_ready;
    logic [LW-1:0]    r_scan, n_scan;
    logic             r_res_ok, n_res_ok;
    logic             r_out_valid, n_out_valid;
    pf_dec_pkg::t_out_word r_out_word;

    // Memories and their registered read data.
    logic [LW-1:0]    r_cells [NC];
    logic [PW-1:0]    r_pos_mem [NA];
    logic [PW-1:0]    r_pos_a, r_pos_b;
    logic [LW-1:0]    r_cell_a, r_cell_b;

    logic             in_take;
    logic             out_free;
    logic             place_en;
    logic [LW-1:0]    place_code;
    logic             place_ok;
    logic             pos_re;
    logic [LW-1:0]    pos_addr_a, pos_addr_b;
    logic             cell_re;
    logic [PW-1:0]    cell_addr_a, cell_addr_b;
    logic             out_load;
    logic [RW-1:0]    row_a, col_a, row_b, col_b;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A letter is placed when it is a real letter, not yet used, and room is left.
    assign place_ok = place_en && (place_code < LW'(NA)) && !r_used[place_code]
                      && (r_fill < PW'(NC));

    assign pos_addr_a = fold_cipher(i_in_word.letter_a);
    assign pos_addr_b = fold_cipher(i_in_word.letter_b);

    assign row_a = pos_row(r_pos_a);
    assign col_a = pos_col(r_pos_a);
    assign row_b = pos_row(r_pos_b);
    assign col_b = pos_col(r_pos_b);

    // Decryption rules: same row shifts left, same column shifts up,
    // otherwise the rectangle corners are swapped.
    always_comb begin
        if (row_a == row_b) begin
            cell_addr_a = cell_index(row_a, step_back(col_a));
            cell_addr_b = cell_index(row_b, step_back(col_b));
        end else if (col_a == col_b) begin
            cell_addr_a = cell_index(step_back(row_a), col_a);
            cell_addr_b = cell_index(step_back(row_b), col_b);
        end else begin
            cell_addr_a = cell_index(row_a, col_b);
            cell_addr_b = cell_index(row_b, col_a);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_fill      = r_fill;
        n_ready     = r_ready;
        n_scan      = r_scan;
        n_res_ok    = r_res_ok;
        n_out_valid = r_out_valid;
        place_en    = 1'b0;
        place_code  = fold_key(i_in_word.letter_a);
        pos_re      = 1'b0;
        cell_re     = 1'b0;
        out_load    = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    unique case (i_in_word.cmd)
                        pf_dec_pkg::CMD_CLEAR: begin
                            n_used  = '0;
                            n_fill  = '0;
                            n_ready = 1'b0;
                        end
                        pf_dec_pkg::CMD_KEY: begin
                            place_en = 1'b1;
                        end
                        pf_dec_pkg::CMD_FINISH: begin
                            n_scan  = pf_dec_pkg::CODE_A;
                            n_state = ST_FILL;
                        end
                        pf_dec_pkg::CMD_DECRYPT: begin
                            n_res_ok = r_ready;
                            if (r_ready) begin
                                pos_re  = 1'b1;
                                n_state = ST_LOOKUP;
                            end else begin
                                n_state = ST_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                place_code = r_scan;
                place_en   = (r_scan != pf_dec_pkg::CODE_J);
                n_scan     = r_scan + LW'(1);
                if (r_scan == pf_dec_pkg::CODE_Z) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOOKUP: begin
                cell_re = 1'b1;
                n_state = ST_CELL;
            end
            ST_CELL: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (place_ok) begin
            n_used[place_code] = 1'b1;
            n_fill             = r_fill + PW'(1);
        end

        // The square is ready once the alphabet walk has filled every cell.
        if (r_state == ST_FILL && r_scan == pf_dec_pkg::CODE_Z) begin
            n_ready = (n_fill >= PW'(NC));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_fill      <= '0;
            r_ready     <= 1'b0;
            r_scan      <= '0;
            r_res_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_fill      <= n_fill;
            r_ready     <= n_ready;
            r_scan      <= n_scan;
            r_res_ok    <= n_res_ok;
            r_out_valid <= n_out_valid;
        end
    end

    // Cell memory: written in fill order, read at two cells for a decrypt.
    always_ff @(posedge i_clk) begin
        if (place_ok) begin
            r_cells[r_fill] <= place_code;
        end
        if (cell_re) begin
            r_cell_a <= r_cells[cell_addr_a];
            r_cell_b <= r_cells[cell_addr_b];
        end
    end

    // Position memory: cell index of each placed letter.
    always_ff @(posedge i_clk) begin
        if (place_ok) begin
            r_pos_mem[place_code] <= r_fill;
        end
        if (pos_re) begin
            r_pos_a <= r_pos_mem[pos_addr_a];
            r_pos_b <= r_pos_mem[pos_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word.plain_a      <= r_res_ok ? r_cell_a : '0;
            r_out_word.plain_b      <= r_res_ok ? r_cell_b : '0;
            r_out_word.square_ready <= r_res_ok;
        end
    end

endmodule

`default_nettype wire

### dv/tb_playfair_decrypt.sv
// Self-checking testbench for playfair_decrypt: random and directed command words,
// checked against a behavioral key-square model kept inside the bench.
// Depends on pf_dec_pkg and the playfair_decrypt top level.
`default_nettype none

module tb_playfair_decrypt;

    localparam int LW   = pf_dec_pkg::LETTER_W;
    localparam int NC   = pf_dec_pkg::CELL_COUNT;
    localparam int NA   = pf_dec_pkg::ALPHA_COUNT;
    localparam int SIDE = pf_dec_pkg::GRID_SIDE;

    // The run ends with a failure when this many cycles in a row pass without
    // a word moving on either side. The longest legal quiet stretch is the
    // deliberate receiver hold-off below, so the limit sits well above it.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    // The drain outlasts the input stall that a finish causes.
    localparam int DRAIN_CYCLES   = 60;
    localparam int STIM_TARGET    = 1350;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    pf_dec_pkg::t_in_word in_word   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    pf_dec_pkg::t_out_word out_word;

    playfair_decrypt i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always #1 clk = ~clk;

    // Words waiting to be offered, and the plaintext results still owed.
    pf_dec_pkg::t_in_word  word_queue[$];
    pf_dec_pkg::t_out_word plain_expect[$];

    int total_words  = 0;
    int drive_count  = 0;
    int stim_count   = 0;
    int accepted_in  = 0;
    int fail_count   = 0;
    int quiet_cycles = 0;
    int idle_phase   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    // ------------------------------------------------------------------
    // Key-square model. The cells and positions are only ever read once
    // the square is ready, at which point all 25 entries have been written.
    // ------------------------------------------------------------------
    logic [LW-1:0] sq_cell [NC];
    logic [LW-1:0] sq_pos  [NA];
    bit            sq_used [NA];
    int            sq_fill  = 0;
    bit            sq_ready = 1'b0;

    initial begin
        foreach (sq_used[i]) sq_used[i] = 1'b0;
    end

    // Appends a letter to the next free cell unless it is out of range,
    // already placed, or the square is full.
    function automatic void place_letter(input logic [LW-1:0] code);
        if (code < NA && !sq_used[code] && sq_fill < NC) begin
            sq_cell[sq_fill] = code;
            sq_pos[code]     = LW'(sq_fill);
            sq_used[code]    = 1'b1;
            sq_fill++;
        end
    endfunction

    // Cipher letters above Z saturate to Z, and J is read as I.
    function automatic logic [LW-1:0] fold_cipher(input logic [LW-1:0] code);
        logic [LW-1:0] c;
        c = (code > pf_dec_pkg::CODE_Z) ? pf_dec_pkg::CODE_Z : code;
        return (c == pf_dec_pkg::CODE_J) ? pf_dec_pkg::CODE_I : c;
    endfunction

    // Applies one accepted word to the model. Returns 1 when the word owes a
    // result, with the expected result in plain.
    function automatic bit apply_word_to_square(input pf_dec_pkg::t_in_word w,
                                                output pf_dec_pkg::t_out_word plain);
        logic [LW-1:0] key;
        int unsigned pa, pb, r1, c1, r2, c2;
        plain = '0;
        case (w.cmd)
            pf_dec_pkg::CMD_CLEAR: begin
                foreach (sq_used[i]) sq_used[i] = 1'b0;
                sq_fill  = 0;
                sq_ready = 1'b0;
                return 1'b0;
            end
            pf_dec_pkg::CMD_KEY: begin
                key = (w.letter_a == pf_dec_pkg::CODE_J) ? pf_dec_pkg::CODE_I : w.letter_a;
                place_letter(key);
                return 1'b0;
            end
            pf_dec_pkg::CMD_FINISH: begin
                for (int c = 0; c < NA; c++) begin
                    if (c != pf_dec_pkg::CODE_J) place_letter(LW'(c));
                end
                if (sq_fill >= NC) sq_ready = 1'b1;
                return 1'b0;
            end
            default: ;
        endcase
        // A decrypt on an unfinished square owes an all-zero result.
        if (!sq_ready) return 1'b1;
        pa = sq_pos[fold_cipher(w.letter_a)];
        pb = sq_pos[fold_cipher(w.letter_b)];
        r1 = pa / SIDE;
        c1 = pa % SIDE;
        r2 = pb / SIDE;
        c2 = pb % SIDE;
        if (r1 == r2) begin
            // Same row: each letter takes its left neighbor, wrapping.
            plain.plain_a = sq_cell[r1 * SIDE + (c1 + SIDE - 1) % SIDE];
            plain.plain_b = sq_cell[r2 * SIDE + (c2 + SIDE - 1) % SIDE];
        end else if (c1 == c2) begin
            // Same column: each letter takes the one above, wrapping.
            plain.plain_a = sq_cell[((r1 + SIDE - 1) % SIDE) * SIDE + c1];
            plain.plain_b = sq_cell[((r2 + SIDE - 1) % SIDE) * SIDE + c2];
        end else begin
            // Rectangle: own row, the other letter's column.
            plain.plain_a = sq_cell[r1 * SIDE + c2];
            plain.plain_b = sq_cell[r2 * SIDE + c1];
        end
        plain.square_ready = 1'b1;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------
    // Key letters out of range do nothing, so they do not count toward the
    // size of the run.
    task automatic queue_word(input pf_dec_pkg::t_cmd c, input int a, input int b);
        pf_dec_pkg::t_in_word w;
        w.cmd      = c;
        w.letter_a = LW'(a);
        w.letter_b = LW'(b);
        word_queue.push_back(w);
        if (c != pf_dec_pkg::CMD_KEY || a < NA) stim_count++;
    endtask

    // Mostly in-range cipher letters, with an occasional one above Z.
    function automatic int cipher_letter();
        return ($urandom_range(15) == 0) ? $urandom_range(31, 26) : $urandom_range(25);
    endfunction

    task automatic queue_session(input bit with_clear, input bit with_finish);
        int n_key;
        int n_dec;
        if (with_clear) begin
            queue_word(pf_dec_pkg::CMD_CLEAR, $urandom_range(31), $urandom_range(31));
        end
        n_key = $urandom_range(30);
        for (int k = 0; k < n_key; k++) begin
            queue_word(pf_dec_pkg::CMD_KEY,
                       ($urandom_range(9) == 0) ? $urandom_range(31, 26) : $urandom_range(25),
                       $urandom_range(31));
        end
        if (with_finish) begin
            queue_word(pf_dec_pkg::CMD_FINISH, $urandom_range(31), $urandom_range(31));
        end
        n_dec = $urandom_range(40, 4);
        for (int d = 0; d < n_dec; d++) begin
            queue_word(pf_dec_pkg::CMD_DECRYPT, cipher_letter(), cipher_letter());
        end
    endtask

    initial begin : stimulus
        int roll;
        int burst;

        // Decrypt straight out of reset: the square is not ready yet.
        queue_word(pf_dec_pkg::CMD_DECRYPT, 0, 31);
        // Key I, A, Z, Q. J folds to I; the out-of-range letters, the repeated
        // A and the later I are all ignored.
        queue_word(pf_dec_pkg::CMD_CLEAR, 0, 0);
        queue_word(pf_dec_pkg::CMD_KEY, pf_dec_pkg::CODE_J, 0);
        queue_word(pf_dec_pkg::CMD_KEY, 31, 31);
        queue_word(pf_dec_pkg::CMD_KEY, 26, 0);
        queue_word(pf_dec_pkg::CMD_KEY, pf_dec_pkg::CODE_A, 0);
        queue_word(pf_dec_pkg::CMD_KEY, pf_dec_pkg::CODE_A, 0);
        queue_word(pf_dec_pkg::CMD_KEY, pf_dec_pkg::CODE_Z, 0);
        queue_word(pf_dec_pkg::CMD_KEY, pf_dec_pkg::CODE_I, 0);
        queue_word(pf_dec_pkg::CMD_KEY, 16, 0);
        // A second finish changes nothing, and a key letter after it is ignored.
        queue_word(pf_dec_pkg::CMD_FINISH, 0, 0);
        queue_word(pf_dec_pkg::CMD_FINISH, 31, 31);
        queue_word(pf_dec_pkg::CMD_KEY, 3, 0);
        // Rows: I A Z Q B / C D E F G / H K L M N / O P R S T / U V W X Y.
        queue_word(pf_dec_pkg::CMD_DECRYPT, 0, 1);      // same row
        queue_word(pf_dec_pkg::CMD_DECRYPT, 8, 1);      // same row, wraps to the right end
        queue_word(pf_dec_pkg::CMD_DECRYPT, 2, 7);      // same column
        queue_word(pf_dec_pkg::CMD_DECRYPT, 8, 20);     // same column, wraps to the bottom
        queue_word(pf_dec_pkg::CMD_DECRYPT, 0, 4);      // rectangle
        queue_word(pf_dec_pkg::CMD_DECRYPT, 5, 5);      // equal letters
        queue_word(pf_dec_pkg::CMD_DECRYPT, 8, 9);      // I and J are the same cell
        queue_word(pf_dec_pkg::CMD_DECRYPT, 9, 31);     // J folded, letter above Z saturated
        queue_word(pf_dec_pkg::CMD_DECRYPT, 26, 30);    // both saturate to Z
        queue_word(pf_dec_pkg::CMD_DECRYPT, 25, 0);
        // Clearing drops the ready state again.
        queue_word(pf_dec_pkg::CMD_CLEAR, 31, 31);
        queue_word(pf_dec_pkg::CMD_DECRYPT, 12, 3);

        // Random part: mostly complete sessions, some broken ones, and
        // bursts of words with every field fully random.
        while (stim_count < STIM_TARGET) begin
            roll = $urandom_range(99);
            if (roll < 78) begin
                queue_session(1'b1, 1'b1);
            end else if (roll < 84) begin
                queue_session(1'b1, 1'b0);
            end else if (roll < 90) begin
                queue_session(1'b0, $urandom_range(1));
            end else begin
                burst = $urandom_range(8, 1);
                for (int n = 0; n < burst; n++) begin
                    queue_word(pf_dec_pkg::t_cmd'($urandom_range(3)),
                               $urandom_range(31), $urandom_range(31));
                end
            end
        end
        total_words = word_queue.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every word has been taken and every result has come back.
        while (word_queue.size() != 0 || in_valid) @(posedge clk);
        while (plain_expect.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender. A new word is offered only once the previous one was taken,
    // so a stalled word never changes. Idle gaps do not look at the stall.
    // The idle rate follows the phase: 34 percent, then 51, then none.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : word_driver
        int idle_pct;
        if (rst_n) begin
            case (idle_phase)
                0:       idle_pct = 34;
                1:       idle_pct = 51;
                default: idle_pct = 0;
            endcase
            if (!in_valid || !in_stall) begin
                if (word_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    in_word  <= word_queue.pop_front();
                    in_valid <= 1'b1;
                    drive_count++;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            if (drive_count < total_words / 3) begin
                idle_phase <= 0;
            end else if (drive_count < 2 * total_words / 3) begin
                idle_phase <= 1;
            end else begin
                idle_phase <= 2;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver. Stalls 51 percent of the time, then 34, then never. Once,
    // at the start of the last phase, it holds off for a long stretch so
    // that results back up and the block stalls its input.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : result_sink
        int stall_pct;
        case (idle_phase)
            0:       stall_pct = 51;
            1:       stall_pct = 34;
            default: stall_pct = 0;
        endcase
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && idle_phase == 2) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor. A result word is checked before the input word of the same
    // edge updates the model, so the order inside the step never matters.
    // It also runs the watchdog on cycles where nothing moves.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : word_monitor
        pf_dec_pkg::t_out_word want;
        pf_dec_pkg::t_out_word got;
        bit                    moved;
        moved = 1'b0;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                moved = 1'b1;
                got   = out_word;
                if (plain_expect.size() == 0) begin
                    $display("%0t: unexpected result plain_a=%0d plain_b=%0d ready=%0b",
                             $time, got.plain_a, got.plain_b, got.square_ready);
                    fail_count++;
                end else begin
                    want = plain_expect.pop_front();
                    if (got.plain_a !== want.plain_a || got.plain_b !== want.plain_b ||
                        got.square_ready !== want.square_ready) begin
                        $display({"%0t: mismatch expected a=%0d b=%0d ready=%0b, ",
                                  "got a=%0d b=%0d ready=%0b"},
                                 $time, want.plain_a, want.plain_b, want.square_ready,
                                 got.plain_a, got.plain_b, got.square_ready);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                moved = 1'b1;
                accepted_in++;
                if (apply_word_to_square(in_word, want)) plain_expect.push_back(want);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
